FILE: rtl/core/wvs_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes for the window variation stability check.
// Used by every module of the block; depends on nothing.
package wvs_pkg;

    // Field widths of the stream items and registers.
    localparam int TPS_W       = 24;
    localparam int FREQ_W      = 16;
    localparam int LIM_W       = 16;
    localparam int WIN_W       = 7;
    localparam int HELD_W      = 7;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    // Partial-product split for the wide limit multiply.
    localparam int SPLIT_W = 32;

    // Register port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Default sample store depth.
    localparam int MAX_WINDOW_DEF = 64;

    // Register reset values.
    localparam logic [WIN_W-1:0] WINDOW_RST   = 7'd10;
    localparam logic [LIM_W-1:0] TPS_LIM_RST  = 16'd3277;
    localparam logic [LIM_W-1:0] FREQ_LIM_RST = 16'd655;

    typedef enum logic
    {
        OP_RECORD = 1'b0,
        OP_CLEAR  = 1'b1
    } wvs_op_t;

    typedef enum logic [1:0]
    {
        REG_WINDOW   = 2'd0,
        REG_TPS_LIM  = 2'd1,
        REG_FREQ_LIM = 2'd2
    } wvs_reg_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_READ,
        ST_WAIT,
        ST_DONE
    } wvs_state_t;

    // Control from the sequencer to the accumulator.
    typedef struct packed
    {
        logic clr;
        logic en;
        logic last;
    } wvs_rd_ctl_t;

    // Verdict from the two channel checkers.
    typedef struct packed
    {
        logic done;
        logic tps_ok;
        logic freq_ok;
    } wvs_judge_t;

endpackage

FILE: rtl/core/window_variation_stability_check.sv
`timescale 1ns / 1ps
// Window variation stability check: top level with the register port.
// Depends on wvs_pkg, wvs_ram, wvs_acc, wvs_chk and wvs_ctrl.

// Each input item either records one throughput and one frequency sample or
// clears the history, and produces exactly one result item that says whether
// the most recent samples of each channel, as many as the window length
// register gives, have a coefficient of variation (population standard
// deviation over mean) no greater than that channel's limit, with stable as
// the AND of both verdicts and held_count as the number of samples held,
// saturating at MAX_WINDOW. A channel fails when fewer samples are held than
// the window length, when the window length is zero, or when its window sum
// is zero. The samples live in one synchronous RAM of MAX_WINDOW words with a
// single read port; the window is re-read from that RAM for every recorded
// sample that is judged, one entry a cycle, and the block takes no new item
// from acceptance until the result of that item is registered in the output
// register, whether the item was a judged sample, a clear or an unjudged one.
// The RAM write of the new sample happens at the acceptance edge, before any
// read of the window, so no forwarding is needed. The store needs no clearing
// after reset: only entries written since the last clear are ever read. A
// finished result sits in an output register, so the block moves on as soon
// as the result is registered, stalling only when a second result is ready
// before the first has been taken. Registers are at byte addresses 0x0
// (window length), 0x4 (tps_cv_limit) and 0x8 (freq_cv_limit) and should be
// written only while the block is idle.
module window_variation_stability_check #(
    parameter int MAX_WINDOW = wvs_pkg::MAX_WINDOW_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input items.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata, low bit up: throughput[23:0], freq_mhz[39:24].
    input  logic [wvs_pkg::IN_TDATA_W-1:0]     s_tdata,
    // tuser: op[0] (0 records a sample, 1 clears the history).
    input  logic [0:0]                         s_tuser,
    // Result items.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // tdata, low bit up: stable[0], tps_ok[1], freq_ok[2], held_count[9:3],
    // zeros[15:10].
    output logic [wvs_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // Register port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wvs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [wvs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [wvs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int AW     = $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int WORD_W = wvs_pkg::TPS_W + wvs_pkg::FREQ_W;
    localparam int TS_W   = wvs_pkg::TPS_W + AW;
    localparam int TQ_W   = 2 * wvs_pkg::TPS_W + AW;
    localparam int FS_W   = wvs_pkg::FREQ_W + AW;
    localparam int FQ_W   = 2 * wvs_pkg::FREQ_W + AW;

    // Configuration registers.
    logic [wvs_pkg::WIN_W-1:0] win_len_reg;
    logic [wvs_pkg::LIM_W-1:0] tps_lim_reg;
    logic [wvs_pkg::LIM_W-1:0] freq_lim_reg;
    wvs_pkg::wvs_reg_t         reg_sel;
    logic                      cfg_wr;

    // Internal connections.
    wvs_pkg::wvs_op_t          in_op;
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [AW-1:0]             rd_addr;
    logic [WORD_W-1:0]         ram_wdata;
    logic [WORD_W-1:0]         ram_rdata;
    wvs_pkg::wvs_rd_ctl_t      rd_ctl;
    wvs_pkg::wvs_judge_t       judge;
    logic                      acc_done;
    logic [TS_W-1:0]           tps_sum;
    logic [TQ_W-1:0]           tps_sqsum;
    logic [FS_W-1:0]           freq_tot;
    logic [FQ_W-1:0]           freq_sqsum;
    logic [CNT_W-1:0]          win_n;
    logic                      tps_done;
    logic                      freq_done;
    logic                      tps_ok;
    logic                      freq_ok;
    logic                      out_stable;
    logic                      out_tps_ok;
    logic                      out_freq_ok;
    logic [wvs_pkg::HELD_W-1:0] out_held;

    // Register port: zero-wait writes in the access phase, plain reads.
    assign pready  = 1'b1;
    assign reg_sel = wvs_pkg::wvs_reg_t'(paddr[wvs_pkg::APB_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg  <= wvs_pkg::WINDOW_RST;
            tps_lim_reg  <= wvs_pkg::TPS_LIM_RST;
            freq_lim_reg <= wvs_pkg::FREQ_LIM_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                wvs_pkg::REG_WINDOW:
                begin
                    win_len_reg <= pwdata[wvs_pkg::WIN_W-1:0];
                end
                wvs_pkg::REG_TPS_LIM:
                begin
                    tps_lim_reg <= pwdata[wvs_pkg::LIM_W-1:0];
                end
                wvs_pkg::REG_FREQ_LIM:
                begin
                    freq_lim_reg <= pwdata[wvs_pkg::LIM_W-1:0];
                end
                default:
                begin
                    // Addresses past the register list are ignored.
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            wvs_pkg::REG_WINDOW:   prdata = wvs_pkg::APB_DATA_W'(win_len_reg);
            wvs_pkg::REG_TPS_LIM:  prdata = wvs_pkg::APB_DATA_W'(tps_lim_reg);
            wvs_pkg::REG_FREQ_LIM: prdata = wvs_pkg::APB_DATA_W'(freq_lim_reg);
            default:               prdata = '0;
        endcase
    end

    // The store word keeps the frequency sample above the throughput sample,
    // which matches the input tdata layout.
    assign in_op     = wvs_pkg::wvs_op_t'(s_tuser[0]);
    assign ram_wdata = s_tdata[WORD_W-1:0];

    // A judged window never exceeds the fill count, so the window length
    // fits the fill counter width.
    assign win_n = CNT_W'(win_len_reg);

    wvs_ctrl #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (in_op),
        .win_len     (win_len_reg),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .rd_addr     (rd_addr),
        .rd_ctl      (rd_ctl),
        .judge       (judge),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_stable  (out_stable),
        .out_tps_ok  (out_tps_ok),
        .out_freq_ok (out_freq_ok),
        .out_held    (out_held)
    );

    wvs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_ctl.en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    wvs_acc #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_acc (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (rd_ctl),
        .rdata      (ram_rdata),
        .done       (acc_done),
        .tps_sum    (tps_sum),
        .tps_sqsum  (tps_sqsum),
        .freq_tot   (freq_tot),
        .freq_sqsum (freq_sqsum)
    );

    wvs_chk #(
        .MAX_WINDOW (MAX_WINDOW),
        .DATA_W     (wvs_pkg::TPS_W)
    ) u_tps_chk (
        .clk   (clk),
        .rst_n (rst_n),
        .start (acc_done),
        .n     (win_n),
        .sum   (tps_sum),
        .sqsum (tps_sqsum),
        .limit (tps_lim_reg),
        .done  (tps_done),
        .ok    (tps_ok)
    );

    wvs_chk #(
        .MAX_WINDOW (MAX_WINDOW),
        .DATA_W     (wvs_pkg::FREQ_W)
    ) u_freq_chk (
        .clk   (clk),
        .rst_n (rst_n),
        .start (acc_done),
        .n     (win_n),
        .sum   (freq_tot),
        .sqsum (freq_sqsum),
        .limit (freq_lim_reg),
        .done  (freq_done),
        .ok    (freq_ok)
    );

    // Both checkers have the same latency, so their done pulses coincide.
    assign judge.done    = tps_done & freq_done;
    assign judge.tps_ok  = tps_ok;
    assign judge.freq_ok = freq_ok;

    assign m_tdata = {
        (wvs_pkg::OUT_TDATA_W - wvs_pkg::HELD_W - 3)'(0),
        out_held,
        out_freq_ok,
        out_tps_ok,
        out_stable
    };

endmodule

FILE: rtl/core/wvs_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; uses no package items other than default sizes.
module wvs_ram #(
    parameter int WIDTH = wvs_pkg::TPS_W + wvs_pkg::FREQ_W,
    parameter int DEPTH = wvs_pkg::MAX_WINDOW_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/wvs_acc.sv
`timescale 1ns / 1ps
// Squares and accumulates the samples read back from the sample store.
// Depends on wvs_pkg for field widths and the read control struct.
module wvs_acc #(
    parameter int MAX_WINDOW = wvs_pkg::MAX_WINDOW_DEF
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  wvs_pkg::wvs_rd_ctl_t                               ctl,
    input  logic [wvs_pkg::TPS_W+wvs_pkg::FREQ_W-1:0]          rdata,
    output logic                                               done,
    output logic [wvs_pkg::TPS_W+$clog2(MAX_WINDOW)-1:0]       tps_sum,
    output logic [2*wvs_pkg::TPS_W+$clog2(MAX_WINDOW)-1:0]     tps_sqsum,
    output logic [wvs_pkg::FREQ_W+$clog2(MAX_WINDOW)-1:0]      freq_tot,
    output logic [2*wvs_pkg::FREQ_W+$clog2(MAX_WINDOW)-1:0]    freq_sqsum
);

    localparam int L      = $clog2(MAX_WINDOW);
    localparam int TS_W   = wvs_pkg::TPS_W + L;
    localparam int TQ_W   = 2 * wvs_pkg::TPS_W + L;
    localparam int FS_W   = wvs_pkg::FREQ_W + L;
    localparam int FQ_W   = 2 * wvs_pkg::FREQ_W + L;

    logic                             rd_vld_reg;
    logic                             rd_last_reg;
    logic                             sq_vld_reg;
    logic                             sq_last_reg;
    logic                             done_reg;
    logic [wvs_pkg::TPS_W-1:0]        val_tps_reg;
    logic [2*wvs_pkg::TPS_W-1:0]      sq_tps_reg;
    logic [wvs_pkg::FREQ_W-1:0]       val_frq_reg;
    logic [2*wvs_pkg::FREQ_W-1:0]     sq_frq_reg;
    logic [TS_W-1:0]                  tps_sum_reg;
    logic [TQ_W-1:0]                  tps_sq_reg;
    logic [FS_W-1:0]                  frq_sum_reg;
    logic [FQ_W-1:0]                  frq_sq_reg;

    logic [wvs_pkg::TPS_W-1:0]        rd_tps;
    logic [wvs_pkg::FREQ_W-1:0]       rd_frq;
    logic [2*wvs_pkg::TPS_W-1:0]      sq_tps_next;
    logic [2*wvs_pkg::FREQ_W-1:0]     sq_frq_next;

    // The store word holds the frequency sample above the throughput sample.
    assign rd_tps      = rdata[wvs_pkg::TPS_W-1:0];
    assign rd_frq      = rdata[wvs_pkg::TPS_W+wvs_pkg::FREQ_W-1:wvs_pkg::TPS_W];
    assign sq_tps_next = rd_tps * rd_tps;
    assign sq_frq_next = rd_frq * rd_frq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            sq_vld_reg  <= 1'b0;
            sq_last_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= ctl.en;
            rd_last_reg <= ctl.en & ctl.last;
            sq_vld_reg  <= rd_vld_reg;
            sq_last_reg <= rd_last_reg;
            done_reg    <= sq_vld_reg & sq_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        val_tps_reg <= rd_tps;
        val_frq_reg <= rd_frq;
        sq_tps_reg  <= sq_tps_next;
        sq_frq_reg  <= sq_frq_next;
        if (ctl.clr)
        begin
            tps_sum_reg <= '0;
            tps_sq_reg  <= '0;
            frq_sum_reg <= '0;
            frq_sq_reg  <= '0;
        end
        else if (sq_vld_reg)
        begin
            tps_sum_reg <= tps_sum_reg + TS_W'(val_tps_reg);
            tps_sq_reg  <= tps_sq_reg + TQ_W'(sq_tps_reg);
            frq_sum_reg <= frq_sum_reg + FS_W'(val_frq_reg);
            frq_sq_reg  <= frq_sq_reg + FQ_W'(sq_frq_reg);
        end
    end

    assign done       = done_reg;
    assign tps_sum    = tps_sum_reg;
    assign tps_sqsum  = tps_sq_reg;
    assign freq_tot   = frq_sum_reg;
    assign freq_sqsum = frq_sq_reg;

endmodule

FILE: rtl/core/wvs_chk.sv
`timescale 1ns / 1ps
// Three-stage coefficient-of-variation test for one channel:
// n*sumsq - sum^2 <= floor(limit^2 * sum^2 / 2^32), failing on a zero sum.
// Depends on wvs_pkg for the limit width and the partial-product split.
module wvs_chk #(
    parameter int MAX_WINDOW = wvs_pkg::MAX_WINDOW_DEF,
    parameter int DATA_W     = wvs_pkg::TPS_W
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]          n,
    input  logic [DATA_W+$clog2(MAX_WINDOW)-1:0]     sum,
    input  logic [2*DATA_W+$clog2(MAX_WINDOW)-1:0]   sqsum,
    input  logic [wvs_pkg::LIM_W-1:0]                limit,
    output logic                                     done,
    output logic                                     ok
);

    localparam int L      = $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = DATA_W + L;
    localparam int SQ_W   = 2 * DATA_W + L;
    localparam int DEV_W  = CNT_W + SQ_W;
    localparam int SSQ_W  = 2 * SUM_W;
    localparam int LSQ_W  = 2 * wvs_pkg::LIM_W;
    localparam int HI_W   = SSQ_W - wvs_pkg::SPLIT_W;
    localparam int PPL_W  = LSQ_W + wvs_pkg::SPLIT_W;
    localparam int PPH_W  = LSQ_W + HI_W;
    localparam int RQ_W   = PPH_W + 1;
    localparam int CMP_W  = (DEV_W > RQ_W) ? DEV_W : RQ_W;

    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;
    logic               nz1_reg;
    logic               nz2_reg;
    logic               ok_reg;
    logic [DEV_W-1:0]   nsq_reg;
    logic [SSQ_W-1:0]   ssq_reg;
    logic [LSQ_W-1:0]   lsq_reg;
    logic [DEV_W-1:0]   dev_reg;
    logic [PPL_W-1:0]   ppl_reg;
    logic [PPH_W-1:0]   pph_reg;

    logic [DEV_W-1:0]   nsq_next;
    logic [SSQ_W-1:0]   ssq_next;
    logic [LSQ_W-1:0]   lsq_next;
    logic [DEV_W-1:0]   dev_next;
    logic [PPL_W-1:0]   ppl_next;
    logic [PPH_W-1:0]   pph_next;
    logic [RQ_W-1:0]    rq;
    logic               ok_next;

    // Stage one: the three independent products.
    assign nsq_next = n * sqsum;
    assign ssq_next = sum * sum;
    assign lsq_next = limit * limit;

    // Stage two: deviation term and the two halves of limit^2 * sum^2.
    assign dev_next = nsq_reg - DEV_W'(ssq_reg);
    assign ppl_next = lsq_reg * ssq_reg[wvs_pkg::SPLIT_W-1:0];
    assign pph_next = lsq_reg * ssq_reg[SSQ_W-1:wvs_pkg::SPLIT_W];

    // Stage three: the right side divided by 2^32 is the high product plus
    // the carry part of the low product; the dropped low bits do not matter
    // because the left side is an integer.
    assign rq      = RQ_W'(pph_reg) + RQ_W'(ppl_reg[PPL_W-1:wvs_pkg::SPLIT_W]);
    assign ok_next = nz2_reg && (CMP_W'(dev_reg) <= CMP_W'(rq));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        nsq_reg <= nsq_next;
        ssq_reg <= ssq_next;
        lsq_reg <= lsq_next;
        nz1_reg <= |sum;
        dev_reg <= dev_next;
        ppl_reg <= ppl_next;
        pph_reg <= pph_next;
        nz2_reg <= nz1_reg;
        ok_reg  <= ok_next;
    end

    assign done = v3_reg;
    assign ok   = ok_reg;

endmodule

FILE: rtl/core/wvs_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: takes items, writes samples, walks the window backward through
// the store, collects the verdict and holds the result item.
// Depends on wvs_pkg for the state, op and struct types.
module wvs_ctrl #(
    parameter int MAX_WINDOW = wvs_pkg::MAX_WINDOW_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  wvs_pkg::wvs_op_t                     in_op,
    input  logic [wvs_pkg::WIN_W-1:0]            win_len,
    output logic                                 ram_we,
    output logic [$clog2(MAX_WINDOW)-1:0]        ram_waddr,
    output logic [$clog2(MAX_WINDOW)-1:0]        rd_addr,
    output wvs_pkg::wvs_rd_ctl_t                 rd_ctl,
    input  wvs_pkg::wvs_judge_t                  judge,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 out_stable,
    output logic                                 out_tps_ok,
    output logic                                 out_freq_ok,
    output logic [wvs_pkg::HELD_W-1:0]           out_held
);

    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (wvs_pkg::WIN_W > CNT_W) ? wvs_pkg::WIN_W : CNT_W;

    wvs_pkg::wvs_state_t state_reg, state_next;

    logic [AW-1:0]              wslot_reg, wslot_next;
    logic [CNT_W-1:0]           fill_reg, fill_next;
    logic [AW-1:0]              rptr_reg, rptr_next;
    logic [CNT_W-1:0]           rcnt_reg, rcnt_next;
    logic                       tok_reg, tok_next;
    logic                       fok_reg, fok_next;
    logic                       ovld_reg, ovld_next;
    logic                       otok_reg, otok_next;
    logic                       ofok_reg, ofok_next;
    logic [wvs_pkg::HELD_W-1:0] oheld_reg, oheld_next;

    logic                       accept;
    logic                       load_out;
    logic                       judge_go;
    logic [AW-1:0]              wslot_inc;
    logic [CNT_W-1:0]           fill_inc;
    logic [CMP_W-1:0]           win_ext;
    logic [CMP_W-1:0]           fill_ext;

    assign accept   = in_valid && (state_reg == wvs_pkg::ST_IDLE);
    assign load_out = (state_reg == wvs_pkg::ST_DONE) && (!ovld_reg || out_ready);

    assign wslot_inc = (wslot_reg == AW'(MAX_WINDOW - 1)) ? '0 : wslot_reg + 1'b1;
    assign fill_inc  = (fill_reg < CNT_W'(MAX_WINDOW)) ? fill_reg + 1'b1 : fill_reg;
    assign win_ext   = CMP_W'(win_len);
    assign fill_ext  = CMP_W'(fill_inc);
    assign judge_go  = (win_len != '0) && (win_ext <= fill_ext);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wvs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_op == wvs_pkg::OP_RECORD && judge_go)
                    begin
                        state_next = wvs_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = wvs_pkg::ST_DONE;
                    end
                end
            end
            wvs_pkg::ST_READ:
            begin
                if (rcnt_reg == CNT_W'(1))
                begin
                    state_next = wvs_pkg::ST_WAIT;
                end
            end
            wvs_pkg::ST_WAIT:
            begin
                if (judge.done)
                begin
                    state_next = wvs_pkg::ST_DONE;
                end
            end
            wvs_pkg::ST_DONE:
            begin
                if (!ovld_reg || out_ready)
                begin
                    state_next = wvs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wvs_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        in_ready    = (state_reg == wvs_pkg::ST_IDLE);
        ram_we      = accept && (in_op == wvs_pkg::OP_RECORD);
        rd_ctl.clr  = accept;
        rd_ctl.en   = (state_reg == wvs_pkg::ST_READ);
        rd_ctl.last = (state_reg == wvs_pkg::ST_READ) && (rcnt_reg == CNT_W'(1));
    end

    // Datapath registers.
    always_comb
    begin
        wslot_next = wslot_reg;
        fill_next  = fill_reg;
        rptr_next  = rptr_reg;
        rcnt_next  = rcnt_reg;
        tok_next   = tok_reg;
        fok_next   = fok_reg;
        ovld_next  = ovld_reg;
        otok_next  = otok_reg;
        ofok_next  = ofok_reg;
        oheld_next = oheld_reg;

        if (accept)
        begin
            tok_next = 1'b0;
            fok_next = 1'b0;
            if (in_op == wvs_pkg::OP_CLEAR)
            begin
                wslot_next = '0;
                fill_next  = '0;
            end
            else
            begin
                wslot_next = wslot_inc;
                fill_next  = fill_inc;
                // The newest sample sits in the slot just written.
                rptr_next  = wslot_reg;
                rcnt_next  = CNT_W'(win_len);
            end
        end

        if (state_reg == wvs_pkg::ST_READ)
        begin
            rptr_next = (rptr_reg == '0) ? AW'(MAX_WINDOW - 1) : rptr_reg - 1'b1;
            rcnt_next = rcnt_reg - 1'b1;
        end

        if (state_reg == wvs_pkg::ST_WAIT && judge.done)
        begin
            tok_next = judge.tps_ok;
            fok_next = judge.freq_ok;
        end

        if (load_out)
        begin
            ovld_next  = 1'b1;
            otok_next  = tok_reg;
            ofok_next  = fok_reg;
            oheld_next = wvs_pkg::HELD_W'(fill_reg);
        end
        else if (out_ready)
        begin
            ovld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wvs_pkg::ST_IDLE;
            wslot_reg <= '0;
            fill_reg  <= '0;
            rcnt_reg  <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wslot_reg <= wslot_next;
            fill_reg  <= fill_next;
            rcnt_reg  <= rcnt_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rptr_reg  <= rptr_next;
        tok_reg   <= tok_next;
        fok_reg   <= fok_next;
        otok_reg  <= otok_next;
        ofok_reg  <= ofok_next;
        oheld_reg <= oheld_next;
    end

    assign ram_waddr   = wslot_reg;
    assign rd_addr     = rptr_reg;
    assign out_valid   = ovld_reg;
    assign out_stable  = otok_reg & ofok_reg;
    assign out_tps_ok  = otok_reg;
    assign out_freq_ok = ofok_reg;
    assign out_held    = oheld_reg;

endmodule

FILE: rtl/core/wvs_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the window variation stability check, and the bind
// that attaches them to the top level. Depends on wvs_pkg.
module wvs_checker #(
    parameter int MAX_WINDOW = wvs_pkg::MAX_WINDOW_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [wvs_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    localparam bit HELD_CAPPED = (MAX_WINDOW < 127);

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // One item is worked on at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on two consecutive cycles");

    // The combined verdict is the AND of the channel verdicts.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[1] && m_tdata[2])))
        else $error("stable does not match the channel verdicts");

    // The held count never exceeds the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!HELD_CAPPED || (int'(m_tdata[9:3]) <= MAX_WINDOW)))
        else $error("held count above store depth");

endmodule

bind window_variation_stability_check wvs_checker #(
    .MAX_WINDOW (MAX_WINDOW)
) u_wvs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
